// ===== sv/lfsa_pkg.sv =====
// Shared constants, types and helper functions of the lowest free slot allocator.
// Used by lfsa_occ and by lowest_free_slot_allocator_core; no dependencies.
`default_nettype none

package lfsa_pkg;

  // Sizing of the slot pool and of the requester table.
  localparam int NUM_SLOTS = 1024;
  localparam int NUM_IDS   = 4096;

  // Occupancy map organization: words of WORD_W slots each.
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int IDX_W     = WADDR_W + BIT_W;
  localparam int SLOT_W    = IDX_W + 1;

  // Requester table: one valid flag plus the held slot per id.
  localparam int ID_AW     = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int TBL_W     = SLOT_W + 1;

  // Fixed field widths of the stream ports.
  localparam int ID_FW     = 12;
  localparam int OUT_FW    = 11;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  // Request codes carried in the input tuser bit.
  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Commands from the controller to the occupancy unit.
  typedef struct packed {
    logic [WADDR_W-1:0] rd_addr;
    logic               we;
    logic [WADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_word;
  } occ_cmd_t;

  // Status from the occupancy unit to the controller.
  typedef struct packed {
    logic [WADDR_W-1:0] free_word;
    logic               any_free;
    logic [WADDR_W-1:0] top_word;
    logic               any_occ;
    logic [WORD_W-1:0]  rd_word;
  } occ_sts_t;

  // Position of the lowest clear bit of a word (0 if none).
  function automatic logic [BIT_W-1:0] low_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // Position of the highest set bit of a word (0 if none).
  function automatic logic [BIT_W-1:0] high_one(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // Bits of a word that lie beyond the last slot; they count as taken.
  function automatic logic [WORD_W-1:0] pad_mask(input logic [WADDR_W-1:0] wa);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (int'(wa) * WORD_W + b >= NUM_SLOTS) m[b] = 1'b1;
    end
    return m;
  endfunction

  // Slot number fitted to the output field width.
  function automatic logic [OUT_FW-1:0] to_out(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+OUT_FW-1:0] ext;
    ext = {{OUT_FW{1'b0}}, s};
    return ext[OUT_FW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/lowest_free_slot_allocator_core.sv =====
// Top level of the lowest free slot allocator: request sequencer and requester table.
// Depends on lfsa_pkg, lfsa_occ and lfsa_ram.
`default_nettype none

// Each request acquires the lowest free slot (numbered from 1) for a requester id
// or releases the slot that the id holds, and yields one result with the slot, the
// highest occupied slot and its peak since reset. After reset the requester table
// is cleared one entry per cycle, all NUM_IDS entries, before the first request
// is taken. A request steps through ST_LOOK, ST_TOP, ST_HI and ST_OUT, and a release
// of a held slot also through ST_REL after ST_LOOK: the table lookup and the
// occupancy word read are issued together on acceptance, a release needs a second
// occupancy read for the freed slot's word, and the highest occupied slot needs a
// read of the top word through the same single occupancy read port. A finished
// result waits in the output register while the next request is accepted.
module lowest_free_slot_allocator_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [lfsa_pkg::IN_DATA_W-1:0]     in_tdata,  // [11:0] requester_id
  input  wire logic                               in_tuser,  // [0] mode
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [10:0] slot, [21:11] highest_occupied, [32:22] peak_highest
  output logic      [lfsa_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic      [lfsa_pkg::OUT_USER_W-1:0]    out_tuser  // [0] full_res, [1] ignored
);

  import lfsa_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_REL   = 3'd3;
  localparam logic [2:0] ST_TOP   = 3'd4;
  localparam logic [2:0] ST_HI    = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [ID_AW-1:0]    clr_cnt_r;
  logic                mode_r;
  logic                id_ok_r;
  logic [WADDR_W-1:0]  free_word_r;
  logic                any_free_r;
  logic [WADDR_W-1:0]  rel_word_r;
  logic [BIT_W-1:0]    rel_bit_r;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                full_flag_r, full_flag_nxt;
  logic                ign_r, ign_nxt;
  logic [WADDR_W-1:0]  top_word_r;
  logic                any_occ_r;
  logic [SLOT_W-1:0]   top_r;
  logic [SLOT_W-1:0]   top_nxt;
  logic [SLOT_W-1:0]   peak_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic                in_acc;
  logic                out_load;
  logic [ID_FW+ID_AW-1:0] id_ext;
  logic [ID_AW-1:0]    id_addr;
  logic                id_ok;

  logic                tbl_we;
  logic [ID_AW-1:0]    tbl_waddr;
  logic [TBL_W-1:0]    tbl_wdata;
  logic [ID_AW-1:0]    tbl_raddr;
  logic [TBL_W-1:0]    tbl_q;
  logic                tbl_valid;
  logic [SLOT_W-1:0]   tbl_slot;
  logic [ID_AW-1:0]    id_r;

  occ_cmd_t            occ_cmd;
  occ_sts_t            occ_sts;

  logic [BIT_W-1:0]    acq_bit;
  logic [IDX_W-1:0]    acq_idx;
  logic [SLOT_W-1:0]   acq_slot;
  logic [IDX_W-1:0]    rel_idx;
  logic [SLOT_W-1:0]   rel_dec;
  logic [IDX_W-1:0]    top_idx;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Requester id as a table address, with the range check against NUM_IDS.
  assign id_ext  = {{ID_AW{1'b0}}, in_tdata[ID_FW-1:0]};
  assign id_addr = id_ext[ID_AW-1:0];
  assign id_ok   = (int'(in_tdata[ID_FW-1:0]) < NUM_IDS);

  assign tbl_valid = tbl_q[TBL_W-1];
  assign tbl_slot  = tbl_q[SLOT_W-1:0];

  // Requester table memory.
  lfsa_ram #(
    .WIDTH (TBL_W),
    .DEPTH (NUM_IDS)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_q)
  );

  lfsa_occ u_occ (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (occ_cmd),
    .sts   (occ_sts)
  );

  // Slot arithmetic for the acquire, release and top-of-map paths.
  assign acq_bit  = low_zero(occ_sts.rd_word | pad_mask(free_word_r));
  assign acq_idx  = {free_word_r, acq_bit};
  assign acq_slot = {1'b0, acq_idx} + SLOT_W'(1);
  assign rel_dec  = tbl_slot - SLOT_W'(1);
  assign rel_idx  = rel_dec[IDX_W-1:0];
  assign top_idx  = {top_word_r, high_one(occ_sts.rd_word)};
  assign top_nxt  = any_occ_r ? ({1'b0, top_idx} + SLOT_W'(1)) : '0;

  // Sequencer: next state, memory accesses and result fields.
  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    full_flag_nxt = full_flag_r;
    ign_nxt       = ign_r;
    tbl_we        = 1'b0;
    tbl_waddr     = id_r;
    tbl_wdata     = '0;
    tbl_raddr     = id_addr;
    occ_cmd.rd_addr = occ_sts.free_word;
    occ_cmd.we      = 1'b0;
    occ_cmd.wr_addr = free_word_r;
    occ_cmd.wr_word = occ_sts.rd_word | (WORD_W'(1) << acq_bit);
    unique case (state_r)
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_cnt_r;
        if (int'(clr_cnt_r) == NUM_IDS - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        slot_nxt      = '0;
        full_flag_nxt = 1'b0;
        ign_nxt       = 1'b0;
        if (in_acc) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        occ_cmd.rd_addr = rel_idx[IDX_W-1:BIT_W];
        state_nxt       = ST_TOP;
        priority if (!id_ok_r) begin
          ign_nxt = 1'b1;
        end else if (mode_r == MODE_ACQUIRE && tbl_valid) begin
          slot_nxt = tbl_slot;
        end else if (mode_r == MODE_ACQUIRE && !any_free_r) begin
          full_flag_nxt = 1'b1;
        end else if (mode_r == MODE_ACQUIRE) begin
          // Take the lowest free slot and record it for the id.
          slot_nxt   = acq_slot;
          occ_cmd.we = 1'b1;
          tbl_we     = 1'b1;
          tbl_wdata  = {1'b1, acq_slot};
        end else if (tbl_valid) begin
          // Release: drop the table entry while the slot's word is fetched.
          slot_nxt  = tbl_slot;
          tbl_we    = 1'b1;
          tbl_wdata = {1'b0, tbl_slot};
          state_nxt = ST_REL;
        end else begin
          ign_nxt = 1'b1;
        end
      end
      ST_REL: begin
        occ_cmd.we      = 1'b1;
        occ_cmd.wr_addr = rel_word_r;
        occ_cmd.wr_word = occ_sts.rd_word & ~(WORD_W'(1) << rel_bit_r);
        state_nxt       = ST_TOP;
      end
      ST_TOP: begin
        occ_cmd.rd_addr = occ_sts.top_word;
        state_nxt       = ST_HI;
      end
      ST_HI: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + ID_AW'(1);
      if (state_r == ST_HI && top_nxt > peak_r) peak_r <= top_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    full_flag_r <= full_flag_nxt;
    ign_r       <= ign_nxt;
    if (in_acc) begin
      mode_r      <= in_tuser;
      id_ok_r     <= id_ok;
      id_r        <= id_addr;
      free_word_r <= occ_sts.free_word;
      any_free_r  <= occ_sts.any_free;
    end
    if (state_r == ST_LOOK) begin
      rel_word_r <= rel_idx[IDX_W-1:BIT_W];
      rel_bit_r  <= rel_idx[BIT_W-1:0];
    end
    if (state_r == ST_TOP) begin
      top_word_r <= occ_sts.top_word;
      any_occ_r  <= occ_sts.any_occ;
    end
    if (state_r == ST_HI) top_r <= top_nxt;
    if (out_load) begin
      out_data_r <= {{(OUT_DATA_W - 3 * OUT_FW){1'b0}},
                     to_out(peak_r), to_out(top_r), to_out(slot_r)};
      out_user_r <= {ign_r, full_flag_r};
    end
  end

endmodule

`default_nettype wire

// ===== sv/lfsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the occupancy map and the requester table.
`default_nettype none

module lfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/lfsa_occ.sv =====
// Occupancy map: a word-organized RAM plus per-word full and nonempty summaries.
// Depends on lfsa_pkg and lfsa_ram.
`default_nettype none

module lfsa_occ (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lfsa_pkg::occ_cmd_t cmd,
  output lfsa_pkg::occ_sts_t     sts
);

  import lfsa_pkg::*;

  logic [NUM_WORDS-1:0] full_r;
  logic [NUM_WORDS-1:0] ne_r;
  logic [WADDR_W-1:0]   rd_addr_r;
  logic [WORD_W-1:0]    ram_q;

  lfsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (cmd.wr_addr),
    .wdata (cmd.wr_word),
    .raddr (cmd.rd_addr),
    .rdata (ram_q)
  );

  // Summary bits follow every word write; an empty word need not be in the RAM.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
      ne_r   <= '0;
    end else if (cmd.we) begin
      full_r[cmd.wr_addr] <= &(cmd.wr_word | pad_mask(cmd.wr_addr));
      ne_r[cmd.wr_addr]   <= |cmd.wr_word;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= cmd.rd_addr;
  end

  // Read word, summaries, lowest word with a free slot and highest word with an
  // occupied slot. A word never written since it was last empty reads as all free.
  always_comb begin
    sts.rd_word   = ne_r[rd_addr_r] ? ram_q : '0;
    sts.any_free  = ~&full_r;
    sts.any_occ   = |ne_r;
    sts.free_word = '0;
    sts.top_word  = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (!full_r[i]) sts.free_word = WADDR_W'(i);
    end
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (ne_r[i]) sts.top_word = WADDR_W'(i);
    end
  end

endmodule

`default_nettype wire

// ===== tb/lfsa_slot_checker.sv =====
// Result checker for the lowest free slot allocator: predicts every accepted request
// and compares each result field by field. Depends on lfsa_pkg.
module lfsa_slot_checker
  import lfsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [11:0] requester_id
  input  wire logic                  in_tuser,   // [0] mode
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  // [10:0] slot, [21:11] highest_occupied, [32:22] peak_highest
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic [OUT_USER_W-1:0] out_tuser,  // [0] full_res, [1] ignored
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    logic [OUT_FW-1:0] slot;
    logic [OUT_FW-1:0] highest;
    logic [OUT_FW-1:0] peak;
    logic              full_res;
    logic              ignored;
  } slot_result_t;

  // Shadow copy of the allocator state.
  bit slot_busy [1:NUM_SLOTS];
  int held_slot_of [NUM_IDS];
  bit id_holds [NUM_IDS];
  int peak_top = 0;

  slot_result_t expected_results [$];
  int mismatches = 0;
  int waiting = 0;

  assign fail_count = mismatches;
  assign pending = waiting;

  // Applies one request to the shadow state and returns the result it must produce.
  function automatic slot_result_t predict_request(logic mode, logic [ID_FW-1:0] id);
    slot_result_t r;
    int s;
    int top;
    int idn;
    r = '0;
    s = 0;
    idn = int'(id);
    if (idn >= NUM_IDS) begin
      r.ignored = 1'b1;
    end else if (mode == MODE_ACQUIRE) begin
      if (id_holds[idn]) begin
        // A requester that already holds a slot just gets it reported again.
        s = held_slot_of[idn];
      end else begin
        for (int k = NUM_SLOTS; k >= 1; k--) begin
          if (!slot_busy[k]) s = k;
        end
        if (s == 0) begin
          r.full_res = 1'b1;
        end else begin
          slot_busy[s] = 1'b1;
          held_slot_of[idn] = s;
          id_holds[idn] = 1'b1;
        end
      end
    end else begin
      if (id_holds[idn]) begin
        s = held_slot_of[idn];
        slot_busy[s] = 1'b0;
        id_holds[idn] = 1'b0;
      end else begin
        r.ignored = 1'b1;
      end
    end
    top = 0;
    for (int k = 1; k <= NUM_SLOTS; k++) begin
      if (slot_busy[k]) top = k;
    end
    if (top > peak_top) peak_top = top;
    r.slot = OUT_FW'(s);
    r.highest = OUT_FW'(top);
    r.peak = OUT_FW'(peak_top);
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Results are matched before requests so that a request accepted on the same
  // edge can never be paired with the result leaving at that edge.
  always @(posedge clk) begin
    slot_result_t got;
    slot_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.slot     = out_tdata[OUT_FW-1:0];
        got.highest  = out_tdata[2*OUT_FW-1:OUT_FW];
        got.peak     = out_tdata[3*OUT_FW-1:2*OUT_FW];
        got.full_res = out_tuser[0];
        got.ignored  = out_tuser[1];
        if (expected_results.size() == 0) begin
          $error("unexpected result: no request outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("slot", want.slot, got.slot);
          check_field("highest_occupied", want.highest, got.highest);
          check_field("peak_highest", want.peak, got.peak);
          check_field("full_res", want.full_res, got.full_res);
          check_field("ignored", want.ignored, got.ignored);
        end
      end
      if (in_tvalid && in_tready) begin
        want = predict_request(in_tuser, in_tdata[ID_FW-1:0]);
        expected_results.insert(expected_results.size(), want);
      end
    end
    waiting = expected_results.size();
  end

endmodule

// ===== tb/tb_lowest_free_slot_allocator_core.sv =====
// Testbench top for lowest_free_slot_allocator_core: drives acquire and release requests
// with random stalls on both sides and gives the verdict. Depends on lfsa_pkg, the core
// and lfsa_slot_checker.
module tb_lowest_free_slot_allocator_core;
  import lfsa_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = MODE_ACQUIRE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  int                    fail_count;
  int                    pending;

  // Idle rates in percent for the request and result sides.
  int tx_idle_pct = 35;
  int rx_idle_pct = 70;

  // Requesters that this side expects to hold a slot, used to shape the stimulus.
  bit                taken_flag [NUM_IDS];
  logic [ID_FW-1:0]  taken_ids [$];

  lowest_free_slot_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  lfsa_slot_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Result side stalls at random.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Presents one request after a random gap and holds it until accepted.
  // Entered and left at a falling edge.
  task automatic send_request(logic mode, logic [ID_FW-1:0] id);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {{(IN_DATA_W-ID_FW){1'b0}}, id};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Sends a request and keeps the list of holding requesters up to date.
  task automatic issue(logic mode, logic [ID_FW-1:0] id);
    if (mode == MODE_ACQUIRE) begin
      if (!taken_flag[id] && taken_ids.size() < NUM_SLOTS) begin
        taken_flag[id] = 1'b1;
        taken_ids.insert(taken_ids.size(), id);
      end
    end else if (taken_flag[id]) begin
      taken_flag[id] = 1'b0;
      for (int k = 0; k < taken_ids.size(); k++) begin
        if (taken_ids[k] == id) begin
          taken_ids.delete(k);
          break;
        end
      end
    end
    send_request(mode, id);
  endtask

  // One random request: mostly fresh acquires and releases of held slots, the rest
  // releases by idle requesters and repeated acquires.
  task automatic random_request(int acq_pct, int rel_pct);
    int r;
    int pick;
    logic [ID_FW-1:0] id;
    r = $urandom_range(99);
    if (r < acq_pct) begin
      do id = ID_FW'($urandom_range(NUM_IDS - 1)); while (taken_flag[id]);
      issue(MODE_ACQUIRE, id);
    end else if (r < acq_pct + rel_pct && taken_ids.size() > 0) begin
      pick = $urandom_range(taken_ids.size() - 1);
      issue(MODE_RELEASE, taken_ids[pick]);
    end else if ($urandom_range(1) == 0 || taken_ids.size() == 0) begin
      do id = ID_FW'($urandom_range(NUM_IDS - 1)); while (taken_flag[id]);
      issue(MODE_RELEASE, id);
    end else begin
      pick = $urandom_range(taken_ids.size() - 1);
      issue(MODE_ACQUIRE, taken_ids[pick]);
    end
  endtask

  // Holds off new requests until every outstanding result has come back.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests: first slots, repeated acquire, releases by idle requesters,
    // reuse of a freed low slot and a return to an empty pool.
    issue(MODE_ACQUIRE, 12'h000);
    issue(MODE_ACQUIRE, 12'hFFF);
    issue(MODE_ACQUIRE, 12'h000);
    issue(MODE_RELEASE, 12'h800);
    issue(MODE_RELEASE, 12'h000);
    issue(MODE_ACQUIRE, 12'hAAA);
    issue(MODE_RELEASE, 12'hFFF);
    issue(MODE_ACQUIRE, 12'h555);
    issue(MODE_RELEASE, 12'hAAA);
    issue(MODE_RELEASE, 12'h555);
    issue(MODE_RELEASE, 12'h555);
    issue(MODE_ACQUIRE, 12'h7FF);
    issue(MODE_ACQUIRE, 12'h800);
    issue(MODE_RELEASE, 12'h7FF);
    issue(MODE_RELEASE, 12'h800);

    // Mixed traffic with a slow result side.
    repeat (450) random_request(70, 20);
    wait_for_drain();

    // Fill the pool, then keep it at the edge so acquires fail and refill holes.
    tx_idle_pct = 70;
    rx_idle_pct = 35;
    while (taken_ids.size() < NUM_SLOTS) random_request(95, 3);
    repeat (60) random_request(60, 30);

    // Drain part of the pool at full rate.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (350) random_request(20, 70);

    wait_for_drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== lowest_free_slot_allocator_core.f =====
sv/lfsa_pkg.sv
sv/lfsa_ram.sv
sv/lfsa_occ.sv
sv/lowest_free_slot_allocator_core.sv
tb/lfsa_slot_checker.sv
tb/tb_lowest_free_slot_allocator_core.sv
